// File: src/iwdd_pkg.sv
// Shared types and constants for the input word debounce and decode block.
// No dependencies; imported by every module of the block.
`default_nettype none

package iwdd_pkg;

   // Fixed widths of the request and response fields.
   localparam int WORD_WIDTH  = 16;
   localparam int TICK_WIDTH  = 16;
   localparam int REV_WIDTH   = 32;
   localparam int CSR_IDX_W   = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_INTERVAL  = 2'd1;

   // Reset values of the configuration registers.
   localparam logic [TICK_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [TICK_WIDTH-1:0] INTERVAL_RESET = 16'd100;

   // Bit positions within the input word.
   localparam int BIT_MANUAL = 0;
   localparam int BIT_AUTO   = 1;
   localparam int BIT_RESET  = 2;
   localparam int BIT_DOWN   = 3;
   localparam int BIT_UP     = 4;
   localparam int BIT_REV    = 5;
   localparam int BIT_CONT   = 10;
   localparam int BIT_C4     = 11;
   localparam int BIT_C3     = 12;
   localparam int BIT_C2     = 13;
   localparam int BIT_C1     = 14;

   // Mode codes.
   localparam logic [1:0] MODE_SEL_IDLE   = 2'd0;
   localparam logic [1:0] MODE_SEL_HAND   = 2'd1;
   localparam logic [1:0] MODE_SEL_SWITCH = 2'd2;

   // Cycle setting codes.
   localparam logic [2:0] CYC_NONE       = 3'd0;
   localparam logic [2:0] CYC_ONE        = 3'd1;
   localparam logic [2:0] CYC_TWO        = 3'd2;
   localparam logic [2:0] CYC_THREE      = 3'd3;
   localparam logic [2:0] CYC_FOUR       = 3'd4;
   localparam logic [2:0] CYC_CONTINUOUS = 3'd5;

   // Decoded switch state produced by the merging stage.
   typedef struct packed {
      logic [1:0] mode;
      logic [2:0] cycle_setting;
      logic       reset_pressed;
      logic       down_pressed;
      logic       up_pressed;
   } decode_type;

   // One complete response.
   typedef struct packed {
      logic [WORD_WIDTH-1:0] latched_word;
      logic [WORD_WIDTH-1:0] debounced_word;
      decode_type            decode;
      logic [REV_WIDTH-1:0]  revolutions;
      logic                  over_temp;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/iwdd_lane.sv
// One debounce lane: the debounced state and saturating age of a single input bit.
// Depends on iwdd_pkg for the threshold width.
`default_nettype none

module iwdd_lane #(
   parameter int AGE_WIDTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             advance,
   input  wire logic                             cur_bit,
   input  wire logic [iwdd_pkg::TICK_WIDTH-1:0]  debounce_ticks,
   output logic                                  deb_next
);
   import iwdd_pkg::*;

   localparam int CMP_W = (AGE_WIDTH > TICK_WIDTH) ? AGE_WIDTH : TICK_WIDTH;

   logic                 deb_ff, deb_in;
   logic [AGE_WIDTH-1:0] age_ff, age_in;
   logic [AGE_WIDTH-1:0] age_inc;
   logic                 take;

   always_comb begin
      age_inc = (age_ff == {AGE_WIDTH{1'b1}}) ? age_ff : age_ff + AGE_WIDTH'(1);
      take    = (cur_bit != deb_ff) && (CMP_W'(age_inc) > CMP_W'(debounce_ticks));
      deb_in  = take ? cur_bit : deb_ff;
      age_in  = take ? '0 : age_inc;
   end

   assign deb_next = deb_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ff <= 1'b0;
         age_ff <= '0;
      end else if (advance) begin
         deb_ff <= deb_in;
         age_ff <= age_in;
      end
   end

endmodule

`default_nettype wire

// File: src/iwdd_merge.sv
// Merging stage: decodes mode, cycle setting and buttons from the debounced lanes.
// Depends on iwdd_pkg for bit positions, codes and decode_type.
`default_nettype none

module iwdd_merge (
   input  wire logic [iwdd_pkg::WORD_WIDTH-1:0] deb_word,
   output iwdd_pkg::decode_type                 decode
);
   import iwdd_pkg::*;

   logic [1:0] mode;

   always_comb begin
      if (deb_word[BIT_MANUAL] && !deb_word[BIT_AUTO]) begin
         mode = MODE_SEL_HAND;
      end else if (!deb_word[BIT_MANUAL] && deb_word[BIT_AUTO]) begin
         mode = MODE_SEL_SWITCH;
      end else begin
         mode = MODE_SEL_IDLE;
      end

      decode.mode = mode;
      if (deb_word[BIT_CONT]) begin
         decode.cycle_setting = CYC_CONTINUOUS;
      end else if (deb_word[BIT_C4]) begin
         decode.cycle_setting = CYC_FOUR;
      end else if (deb_word[BIT_C3]) begin
         decode.cycle_setting = CYC_THREE;
      end else if (deb_word[BIT_C2]) begin
         decode.cycle_setting = CYC_TWO;
      end else if (deb_word[BIT_C1]) begin
         decode.cycle_setting = CYC_ONE;
      end else begin
         decode.cycle_setting = CYC_NONE;
      end
      decode.reset_pressed = deb_word[BIT_RESET];
      decode.down_pressed  = (mode == MODE_SEL_HAND) && deb_word[BIT_DOWN];
      decode.up_pressed    = (mode == MODE_SEL_HAND) && deb_word[BIT_UP];
   end

endmodule

`default_nettype wire

// File: src/iwdd_out_buf.sv
// Two-entry response buffer that decouples the tick datapath from response back-pressure.
// Depends on iwdd_pkg for rsp_type.
`default_nettype none

module iwdd_out_buf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire iwdd_pkg::rsp_type push_data,
   output logic                   has_room,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output iwdd_pkg::rsp_type      out_data
);
   import iwdd_pkg::*;

   rsp_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign has_room  = (count_ff != 2'd2);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: src/input_word_debounce_and_decode_core.sv
// Input word debounce and decode, top level. Depends on iwdd_pkg, iwdd_lane,
// iwdd_merge and iwdd_out_buf.
// A response is registered in a two-entry response buffer and offered after older ones.
// Throughput: one request per cycle while that buffer has room; each tick is a single pass
// through the lanes, and the buffer keeps requests flowing while a response waits.
// Reset (synchronous, active high) clears all ages, debounced bits, the latch and the count.
`default_nettype none

module input_word_debounce_and_decode_core #(
   parameter int NUM_INPUTS  = 16,
   parameter int AGE_WIDTH   = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel: one millisecond tick per request.
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [iwdd_pkg::WORD_WIDTH-1:0]   req_raw_word,
   input  wire logic                              req_temp_pin_n,
   input  wire logic                              req_clear_revolutions,
   // Response channel.
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [iwdd_pkg::WORD_WIDTH-1:0]        rsp_latched_word,
   output logic [iwdd_pkg::WORD_WIDTH-1:0]        rsp_debounced_word,
   output logic [1:0]                             rsp_mode,
   output logic [2:0]                             rsp_cycle_setting,
   output logic                                   rsp_reset_pressed,
   output logic                                   rsp_down_pressed,
   output logic                                   rsp_up_pressed,
   output logic [iwdd_pkg::REV_WIDTH-1:0]         rsp_revolutions,
   output logic                                   rsp_over_temp,
   // Configuration write port.
   input  wire logic                              csr_write_en,
   input  wire logic [iwdd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [iwdd_pkg::TICK_WIDTH-1:0]   csr_wdata
);
   import iwdd_pkg::*;

   // Configuration registers.
   logic [TICK_WIDTH-1:0] debounce_ticks_ff;
   logic [TICK_WIDTH-1:0] read_interval_ff;

   // Tick state: read age, latched word, revolution edge detector and counter.
   logic [TICK_WIDTH-1:0]  read_age_ff, read_age_in;
   logic [TICK_WIDTH-1:0]  read_age_inc;
   logic [NUM_INPUTS-1:0]  latched_ff, latched_in;
   logic [NUM_INPUTS-1:0]  raw_ext;
   logic                   prev_rev_ff, prev_rev_in;
   logic [COUNT_WIDTH-1:0] rev_count_ff, rev_count_in;

   logic                   accept;
   logic [NUM_INPUTS-1:0]  deb_next;
   logic [WORD_WIDTH-1:0]  deb_word;
   logic [WORD_WIDTH-1:0]  latched_word;
   decode_type             decode;
   rsp_type                rsp_new;
   rsp_type                rsp_out;
   logic                   buf_room;

   assign accept    = req_valid && req_ready;
   assign req_ready = buf_room;

   // Configuration writes; indexes beyond the register list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= DEBOUNCE_RESET;
         read_interval_ff  <= INTERVAL_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_wdata;
            CSR_READ_INTERVAL:  read_interval_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The raw word is mapped onto the lanes; lanes beyond the raw word read zero,
   // and raw bits beyond the lane count are dropped.
   for (genvar i = 0; i < NUM_INPUTS; i++) begin : g_raw
      if (i < WORD_WIDTH) begin : g_bit
         assign raw_ext[i] = req_raw_word[i];
      end else begin : g_pad
         assign raw_ext[i] = 1'b0;
      end
   end

   // The read age saturates rather than wrapping. When it reaches the interval,
   // the raw word is latched during this same tick and the age restarts.
   always_comb begin
      read_age_inc = (read_age_ff == {TICK_WIDTH{1'b1}}) ? read_age_ff
                                                           : read_age_ff + TICK_WIDTH'(1);
      if (read_age_inc >= read_interval_ff) begin
         latched_in  = raw_ext;
         read_age_in = '0;
      end else begin
         latched_in  = latched_ff;
         read_age_in = read_age_inc;
      end
   end

   // One debounce lane per input bit, all working on the freshly latched word.
   for (genvar i = 0; i < NUM_INPUTS; i++) begin : g_lane
      iwdd_lane #(
         .AGE_WIDTH(AGE_WIDTH)
      ) u_lane (
         .clock         (clock),
         .reset         (reset),
         .advance       (accept),
         .cur_bit       (latched_in[i]),
         .debounce_ticks(debounce_ticks_ff),
         .deb_next      (deb_next[i])
      );
   end

   // Gather the lanes into the fixed-width response words; positions without a
   // lane read as zero.
   for (genvar i = 0; i < WORD_WIDTH; i++) begin : g_word
      if (i < NUM_INPUTS) begin : g_bit
         assign deb_word[i]     = deb_next[i];
         assign latched_word[i] = latched_in[i];
      end else begin : g_pad
         assign deb_word[i]     = 1'b0;
         assign latched_word[i] = 1'b0;
      end
   end

   iwdd_merge u_merge (
      .deb_word(deb_word),
      .decode  (decode)
   );

   // Rising edges of the latched revolution bit are counted; a clear request
   // takes priority over an edge in the same tick.
   always_comb begin
      prev_rev_in = latched_in[BIT_REV];
      if (req_clear_revolutions) begin
         rev_count_in = '0;
      end else if (latched_in[BIT_REV] && !prev_rev_ff) begin
         rev_count_in = rev_count_ff + COUNT_WIDTH'(1);
      end else begin
         rev_count_in = rev_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_age_ff  <= '0;
         latched_ff   <= '0;
         prev_rev_ff  <= 1'b0;
         rev_count_ff <= '0;
      end else if (accept) begin
         read_age_ff  <= read_age_in;
         latched_ff   <= latched_in;
         prev_rev_ff  <= prev_rev_in;
         rev_count_ff <= rev_count_in;
      end
   end

   always_comb begin
      rsp_new.latched_word   = latched_word;
      rsp_new.debounced_word = deb_word;
      rsp_new.decode         = decode;
      rsp_new.revolutions    = REV_WIDTH'(rev_count_in);
      rsp_new.over_temp      = ~req_temp_pin_n;
   end

   iwdd_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_data(rsp_new),
      .has_room (buf_room),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_data (rsp_out)
   );

   assign rsp_latched_word   = rsp_out.latched_word;
   assign rsp_debounced_word = rsp_out.debounced_word;
   assign rsp_mode           = rsp_out.decode.mode;
   assign rsp_cycle_setting  = rsp_out.decode.cycle_setting;
   assign rsp_reset_pressed  = rsp_out.decode.reset_pressed;
   assign rsp_down_pressed   = rsp_out.decode.down_pressed;
   assign rsp_up_pressed     = rsp_out.decode.up_pressed;
   assign rsp_revolutions    = rsp_out.revolutions;
   assign rsp_over_temp      = rsp_out.over_temp;

endmodule

`default_nettype wire

// File: verif/tb_input_word_debounce_and_decode_core.sv
// Self-checking testbench for input_word_debounce_and_decode_core: a directed table of ticks and
// register writes, then random switch traffic, each response compared with an in-bench model.
// Depends on iwdd_pkg and the core RTL only.
`default_nettype none

module tb_input_word_debounce_and_decode_core;
   import iwdd_pkg::*;

   // A run is stopped when no request and no response has moved for longer than this limit. The
   // longest legal quiet stretch is the longest sender gap or two all-stall receiver patterns.
   localparam int WATCHDOG_LIMIT = 400;
   // Beyond this many mismatches the lines are only counted, not printed.
   localparam int MAX_REPORTS = 200;

   // Register indexes past the end of the register list; writes to them are ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   // The per-bit and read ages saturate at the all-ones value.
   localparam logic [TICK_WIDTH-1:0] AGE_MAX = '1;

   typedef enum logic {
      ROW_TICK,
      ROW_CSR
   } row_kind_type;

   // One row of the directed table: either a tick request or a register write. Where the
   // response can be read straight off the behaviour, it is typed in and checked as given.
   typedef struct {
      row_kind_type          kind;
      logic [WORD_WIDTH-1:0] raw;
      logic                  temp_n;
      logic                  clr;
      logic [CSR_IDX_W-1:0]  idx;
      logic [TICK_WIDTH-1:0] wdata;
      bit                    typed;
      rsp_type               want;
   } stim_row_type;

   // ---------------------------------------------------------------------------------------
   // Signals to and from the block.
   // ---------------------------------------------------------------------------------------
   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [WORD_WIDTH-1:0]  req_raw_word;
   logic                   req_temp_pin_n;
   logic                   req_clear_revolutions;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [WORD_WIDTH-1:0]  rsp_latched_word;
   logic [WORD_WIDTH-1:0]  rsp_debounced_word;
   logic [1:0]             rsp_mode;
   logic [2:0]             rsp_cycle_setting;
   logic                   rsp_reset_pressed;
   logic                   rsp_down_pressed;
   logic                   rsp_up_pressed;
   logic [REV_WIDTH-1:0]   rsp_revolutions;
   logic                   rsp_over_temp;
   logic                   csr_write_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [TICK_WIDTH-1:0]  csr_wdata;

   input_word_debounce_and_decode_core u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_raw_word          (req_raw_word),
      .req_temp_pin_n        (req_temp_pin_n),
      .req_clear_revolutions (req_clear_revolutions),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_latched_word      (rsp_latched_word),
      .rsp_debounced_word    (rsp_debounced_word),
      .rsp_mode              (rsp_mode),
      .rsp_cycle_setting     (rsp_cycle_setting),
      .rsp_reset_pressed     (rsp_reset_pressed),
      .rsp_down_pressed      (rsp_down_pressed),
      .rsp_up_pressed        (rsp_up_pressed),
      .rsp_revolutions       (rsp_revolutions),
      .rsp_over_temp         (rsp_over_temp),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Debounce model. It keeps its own copy of the registers and of every age and debounced
   // bit, and is stepped once for each request that the block accepts.
   // ---------------------------------------------------------------------------------------
   logic [TICK_WIDTH-1:0] cfg_debounce;
   logic [TICK_WIDTH-1:0] cfg_interval;
   logic [WORD_WIDTH-1:0] sw_latched;
   logic [WORD_WIDTH-1:0] sw_debounced;
   logic [TICK_WIDTH-1:0] sw_read_age;
   logic [TICK_WIDTH-1:0] sw_bit_age [WORD_WIDTH];
   logic                  sw_prev_rev;
   logic [REV_WIDTH-1:0]  sw_revs;

   // Responses still owed by the block, oldest first.
   rsp_type               owed_responses [$];
   stim_row_type          stim_rows [$];

   int unsigned           ticks_sent;
   int unsigned           responses_seen;
   int unsigned           csr_writes;
   int unsigned           error_count;
   int unsigned           quiet_cycles = 0;
   int                    burst_left;

   // State of the switch traffic generator.
   logic [WORD_WIDTH-1:0] target_word;
   int                    hold_left;
   int                    bounce_left;
   int                    hold_max;

   function automatic rsp_type debounce_tick(input logic [WORD_WIDTH-1:0] raw,
                                             input logic temp_n, input logic clr);
      rsp_type r;
      int      i;
      logic    rev;
      // The read age advances first, so with a zero interval the word is latched every tick.
      if (sw_read_age != AGE_MAX) sw_read_age = sw_read_age + 16'd1;
      if (sw_read_age >= cfg_interval) begin
         sw_latched  = raw;
         sw_read_age = '0;
      end
      // Lockout debounce: a changed bit is taken only once its age is beyond the delay.
      for (i = 0; i < WORD_WIDTH; i++) begin
         if (sw_bit_age[i] != AGE_MAX) sw_bit_age[i] = sw_bit_age[i] + 16'd1;
         if (sw_latched[i] != sw_debounced[i] && sw_bit_age[i] > cfg_debounce) begin
            sw_debounced[i] = sw_latched[i];
            sw_bit_age[i]   = '0;
         end
      end
      // Revolution edges come from the latched word, not the debounced one; a clear wins.
      rev = sw_latched[BIT_REV];
      if (clr) sw_revs = '0;
      else if (rev && !sw_prev_rev) sw_revs = sw_revs + REV_WIDTH'(1);
      sw_prev_rev = rev;

      r = '0;
      r.latched_word   = sw_latched;
      r.debounced_word = sw_debounced;
      if (sw_debounced[BIT_MANUAL] && !sw_debounced[BIT_AUTO]) r.decode.mode = MODE_SEL_HAND;
      else if (!sw_debounced[BIT_MANUAL] && sw_debounced[BIT_AUTO])
         r.decode.mode = MODE_SEL_SWITCH;
      else r.decode.mode = MODE_SEL_IDLE;
      if (sw_debounced[BIT_CONT]) r.decode.cycle_setting = CYC_CONTINUOUS;
      else if (sw_debounced[BIT_C4]) r.decode.cycle_setting = CYC_FOUR;
      else if (sw_debounced[BIT_C3]) r.decode.cycle_setting = CYC_THREE;
      else if (sw_debounced[BIT_C2]) r.decode.cycle_setting = CYC_TWO;
      else if (sw_debounced[BIT_C1]) r.decode.cycle_setting = CYC_ONE;
      else r.decode.cycle_setting = CYC_NONE;
      r.decode.reset_pressed = sw_debounced[BIT_RESET];
      r.decode.down_pressed  = (r.decode.mode == MODE_SEL_HAND) && sw_debounced[BIT_DOWN];
      r.decode.up_pressed    = (r.decode.mode == MODE_SEL_HAND) && sw_debounced[BIT_UP];
      r.revolutions          = sw_revs;
      r.over_temp            = ~temp_n;
      return r;
   endfunction

   // Builds a typed response for the directed table.
   function automatic rsp_type make_response(input logic [WORD_WIDTH-1:0] latched,
                                             input logic [WORD_WIDTH-1:0] debounced,
                                             input logic [1:0] mode, input logic [2:0] cyc,
                                             input logic rst, input logic down, input logic up,
                                             input logic [REV_WIDTH-1:0] revs,
                                             input logic alarm);
      rsp_type r;
      r.latched_word         = latched;
      r.debounced_word       = debounced;
      r.decode.mode          = mode;
      r.decode.cycle_setting = cyc;
      r.decode.reset_pressed = rst;
      r.decode.down_pressed  = down;
      r.decode.up_pressed    = up;
      r.revolutions          = revs;
      r.over_temp            = alarm;
      return r;
   endfunction

   function automatic void add_tick(input logic [WORD_WIDTH-1:0] raw, input logic temp_n,
                                    input logic clr);
      stim_row_type row;
      row        = '{kind: ROW_TICK, default: '0};
      row.raw    = raw;
      row.temp_n = temp_n;
      row.clr    = clr;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_typed(input logic [WORD_WIDTH-1:0] raw, input logic temp_n,
                                     input logic clr, input rsp_type want);
      stim_row_type row;
      row        = '{kind: ROW_TICK, default: '0};
      row.raw    = raw;
      row.temp_n = temp_n;
      row.clr    = clr;
      row.typed  = 1'b1;
      row.want   = want;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_csr(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [TICK_WIDTH-1:0] wdata);
      stim_row_type row;
      row       = '{kind: ROW_CSR, default: '0};
      row.idx   = idx;
      row.wdata = wdata;
      stim_rows.push_back(row);
   endfunction

   // Switch traffic: a target word is held for a while, often with a few bounces at the start,
   // and now and then a tick of pure noise. Most changes toggle one switch, and the revolution
   // bit is toggled often so that edges keep coming.
   function automatic logic [WORD_WIDTH-1:0] next_switch_word();
      logic [31:0] noise;
      if (hold_left == 0) begin
         case ($urandom_range(0, 7))
            0: target_word = WORD_WIDTH'($urandom);
            1: begin
               target_word[BIT_MANUAL] = 1'($urandom_range(0, 1));
               target_word[BIT_AUTO]   = 1'($urandom_range(0, 1));
            end
            default: begin
               target_word = target_word ^ (16'h0001 << $urandom_range(0, WORD_WIDTH - 1));
               if ($urandom_range(0, 1) == 1) target_word[BIT_REV] = ~target_word[BIT_REV];
            end
         endcase
         hold_left   = $urandom_range(1, hold_max);
         bounce_left = $urandom_range(0, 3);
      end
      hold_left--;
      noise = $urandom;
      if ($urandom_range(0, 15) == 0) return noise[WORD_WIDTH-1:0];
      if (bounce_left > 0) begin
         bounce_left--;
         return target_word ^ (16'h0001 << $urandom_range(0, WORD_WIDTH - 1));
      end
      return target_word;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Mismatch reporting.
   // ---------------------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("t=%0t %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // ---------------------------------------------------------------------------------------
   // Sender. Requests go out in bursts of random length separated by random gaps. The valid
   // is only lowered where a gap really follows, so it never drops and rises in one step.
   // ---------------------------------------------------------------------------------------
   task automatic send_tick(input logic [WORD_WIDTH-1:0] raw, input logic temp_n,
                            input logic clr, input bit typed, input rsp_type typed_rsp);
      int      gap;
      rsp_type predicted;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
         if ($urandom_range(0, 15) == 0) gap = $urandom_range(13, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid             <= 1'b1;
      req_raw_word          <= raw;
      req_temp_pin_n        <= temp_n;
      req_clear_revolutions <= clr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // The request went in at this edge, so the model steps now.
      predicted = debounce_tick(raw, temp_n, clr);
      owed_responses.push_back(typed ? typed_rsp : predicted);
      ticks_sent++;
   endtask

   // Holds the sender back until every owed response has arrived. It always lets at least
   // one edge pass, so a valid lowered here is never raised again in the same step.
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_responses.size() != 0) @(posedge clock);
   endtask

   // Register writes only happen with the block idle. The caller lowers the write enable.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [TICK_WIDTH-1:0] data);
      wait_for_responses();
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      if (idx == CSR_DEBOUNCE_TICKS) cfg_debounce = data;
      else if (idx == CSR_READ_INTERVAL) cfg_interval = data;
      csr_writes++;
   endtask

   // ---------------------------------------------------------------------------------------
   // Receiver. The ready follows a 16-bit stall pattern that is redrawn whenever its phase wraps:
   // either no stalls at all, random stalls, or heavy stalls.
   // ---------------------------------------------------------------------------------------
   logic [15:0] stall_pattern = 16'hFFFF;
   logic [3:0]  stall_phase   = 4'd0;

   always @(posedge clock) begin
      stall_phase <= stall_phase + 4'd1;
      if (stall_phase == 4'd15) begin
         case ($urandom_range(0, 2))
            0:       stall_pattern <= 16'hFFFF;
            1:       stall_pattern <= 16'($urandom);
            default: stall_pattern <= 16'($urandom & $urandom);
         endcase
      end
      rsp_ready <= stall_pattern[stall_phase];
   end

   // ---------------------------------------------------------------------------------------
   // Response checker: each accepted response is compared with the oldest one owed.
   // ---------------------------------------------------------------------------------------
   rsp_type want_rsp;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (owed_responses.size() == 0) begin
            report_mismatch("response with no request outstanding", 32'(rsp_latched_word), 0);
         end else begin
            want_rsp = owed_responses.pop_front();
            check_field("latched_word", 32'(rsp_latched_word), 32'(want_rsp.latched_word));
            check_field("debounced_word", 32'(rsp_debounced_word),
                        32'(want_rsp.debounced_word));
            check_field("mode", 32'(rsp_mode), 32'(want_rsp.decode.mode));
            check_field("cycle_setting", 32'(rsp_cycle_setting),
                        32'(want_rsp.decode.cycle_setting));
            check_field("reset_pressed", 32'(rsp_reset_pressed),
                        32'(want_rsp.decode.reset_pressed));
            check_field("down_pressed", 32'(rsp_down_pressed),
                        32'(want_rsp.decode.down_pressed));
            check_field("up_pressed", 32'(rsp_up_pressed), 32'(want_rsp.decode.up_pressed));
            check_field("revolutions", rsp_revolutions, want_rsp.revolutions);
            check_field("over_temp", 32'(rsp_over_temp), 32'(want_rsp.over_temp));
         end
      end
   end

   // Watchdog: counts cycles in which neither channel moves a request or a response.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no traffic for %0d cycles, %0d responses still owed.",
                     quiet_cycles, owed_responses.size());
            $display("FAIL input_word_debounce_and_decode_core");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------------------------
   initial begin
      stim_row_type          row;
      int                    ph;
      int                    n;
      int                    phase_items;
      logic [TICK_WIDTH-1:0] deb_val;
      logic [TICK_WIDTH-1:0] int_val;

      // Every input is known from the first instant; reset is held high at the start.
      reset                 <= 1'b1;
      req_valid             <= 1'b0;
      req_raw_word          <= '0;
      req_temp_pin_n        <= 1'b1;
      req_clear_revolutions <= 1'b0;
      csr_write_en          <= 1'b0;
      csr_index             <= CSR_DEBOUNCE_TICKS;
      csr_wdata             <= '0;

      // The model starts from the reset state of the block.
      cfg_debounce = DEBOUNCE_RESET;
      cfg_interval = INTERVAL_RESET;
      sw_latched   = '0;
      sw_debounced = '0;
      sw_read_age  = '0;
      foreach (sw_bit_age[i]) sw_bit_age[i] = '0;
      sw_prev_rev    = 1'b0;
      sw_revs        = '0;
      ticks_sent     = 0;
      responses_seen = 0;
      csr_writes     = 0;
      error_count    = 0;
      burst_left     = 0;
      target_word    = '0;
      hold_left      = 0;
      bounce_left    = 0;
      hold_max       = 8;

      // Straight after reset the interval has not run out, so nothing is latched yet and
      // only the temperature alarm follows its pin.
      add_typed(16'hFFFF, 1'b0, 1'b0,
                make_response('0, '0, MODE_SEL_IDLE, CYC_NONE, 0, 0, 0, 0, 1));
      add_typed(16'h0000, 1'b1, 1'b1,
                make_response('0, '0, MODE_SEL_IDLE, CYC_NONE, 0, 0, 0, 0, 0));
      // A zero interval latches on every tick and a zero delay takes each change at once,
      // so the debounced word simply follows the raw word. Writes past the register list
      // must leave both settings alone.
      add_csr(CSR_DEBOUNCE_TICKS, 16'd0);
      add_csr(CSR_READ_INTERVAL, 16'd0);
      add_csr(CSR_SPARE_A, 16'hFFFF);
      add_csr(CSR_SPARE_B, 16'hFFFF);
      add_typed(16'h0001, 1'b1, 1'b0,
                make_response(16'h0001, 16'h0001, MODE_SEL_HAND, CYC_NONE, 0, 0, 0, 0, 0));
      // Buttons pass in manual mode only; both mode switches on means off.
      add_typed(16'h0019, 1'b1, 1'b0,
                make_response(16'h0019, 16'h0019, MODE_SEL_HAND, CYC_NONE, 0, 1, 1, 0, 0));
      add_typed(16'h001A, 1'b1, 1'b0,
                make_response(16'h001A, 16'h001A, MODE_SEL_SWITCH, CYC_NONE, 0, 0, 0, 0, 0));
      add_typed(16'h0003, 1'b1, 1'b0,
                make_response(16'h0003, 16'h0003, MODE_SEL_IDLE, CYC_NONE, 0, 0, 0, 0, 0));
      // Reset button and a first revolution edge.
      add_typed(16'h0024, 1'b1, 1'b0,
                make_response(16'h0024, 16'h0024, MODE_SEL_IDLE, CYC_NONE, 1, 0, 0, 1, 0));
      add_typed(16'h0000, 1'b1, 1'b0,
                make_response(16'h0000, 16'h0000, MODE_SEL_IDLE, CYC_NONE, 0, 0, 0, 1, 0));
      // A clear on the very tick of an edge wins over the increment.
      add_typed(16'h0020, 1'b1, 1'b1,
                make_response(16'h0020, 16'h0020, MODE_SEL_IDLE, CYC_NONE, 0, 0, 0, 0, 0));
      add_typed(16'h0000, 1'b1, 1'b0,
                make_response(16'h0000, 16'h0000, MODE_SEL_IDLE, CYC_NONE, 0, 0, 0, 0, 0));
      add_typed(16'h0020, 1'b1, 1'b0,
                make_response(16'h0020, 16'h0020, MODE_SEL_IDLE, CYC_NONE, 0, 0, 0, 1, 0));
      // Cycle setting by priority, highest first, then the unused top bit alone.
      add_typed(16'h7C00, 1'b1, 1'b0,
                make_response(16'h7C00, 16'h7C00, MODE_SEL_IDLE, CYC_CONTINUOUS,
                              0, 0, 0, 1, 0));
      add_typed(16'h7800, 1'b1, 1'b0,
                make_response(16'h7800, 16'h7800, MODE_SEL_IDLE, CYC_FOUR, 0, 0, 0, 1, 0));
      add_typed(16'h7000, 1'b1, 1'b0,
                make_response(16'h7000, 16'h7000, MODE_SEL_IDLE, CYC_THREE, 0, 0, 0, 1, 0));
      add_typed(16'h6000, 1'b1, 1'b0,
                make_response(16'h6000, 16'h6000, MODE_SEL_IDLE, CYC_TWO, 0, 0, 0, 1, 0));
      add_typed(16'h4000, 1'b1, 1'b0,
                make_response(16'h4000, 16'h4000, MODE_SEL_IDLE, CYC_ONE, 0, 0, 0, 1, 0));
      add_typed(16'h8000, 1'b1, 1'b0,
                make_response(16'h8000, 16'h8000, MODE_SEL_IDLE, CYC_NONE, 0, 0, 0, 1, 0));
      add_typed(16'hFFFF, 1'b0, 1'b0,
                make_response(16'hFFFF, 16'hFFFF, MODE_SEL_IDLE, CYC_CONTINUOUS,
                              1, 0, 0, 2, 1));
      // With the delay at the age maximum no bit can ever change, though the latch and the
      // revolution count still follow the raw word.
      add_csr(CSR_DEBOUNCE_TICKS, 16'hFFFF);
      add_tick(16'h0000, 1'b1, 1'b0);
      add_tick(16'h0020, 1'b1, 1'b0);
      // A short delay: the lockout holds off changes that come too soon after the last one.
      add_csr(CSR_DEBOUNCE_TICKS, 16'd2);
      add_csr(CSR_READ_INTERVAL, 16'd2);
      add_tick(16'h0001, 1'b1, 1'b0);
      add_tick(16'h0001, 1'b0, 1'b0);
      add_tick(16'h0002, 1'b1, 1'b0);
      add_tick(16'h0002, 1'b1, 1'b0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[k]) begin
         row = stim_rows[k];
         if (row.kind == ROW_CSR) begin
            write_register(row.idx, row.wdata);
         end else begin
            csr_write_en <= 1'b0;
            send_tick(row.raw, row.temp_n, row.clr, row.typed, row.want);
         end
      end

      // Random part: ten settings, the extremes among them, with switch traffic under each.
      // Most settings keep the delay and interval small so that bits change often.
      for (ph = 0; ph < 10; ph++) begin
         case (ph)
            0: begin
               deb_val = 16'd0;
               int_val = 16'd1;
            end
            1: begin
               deb_val = 16'd65534;
               int_val = 16'd1;
            end
            2: begin
               deb_val = 16'd1;
               int_val = 16'd65535;
            end
            5: begin
               deb_val = TICK_WIDTH'($urandom_range(10, 40));
               int_val = TICK_WIDTH'($urandom_range(1, 5));
            end
            default: begin
               deb_val = TICK_WIDTH'($urandom_range(0, 6));
               int_val = TICK_WIDTH'($urandom_range(1, 5));
            end
         endcase
         write_register(CSR_DEBOUNCE_TICKS, deb_val);
         write_register(CSR_READ_INTERVAL, int_val);
         csr_write_en <= 1'b0;
         hold_max = int'(deb_val) + 2 * int'(int_val) + 4;
         if (hold_max > 48) hold_max = 48;
         phase_items = (ph == 1 || ph == 2) ? 60 : 210;
         for (n = 0; n < phase_items; n++) begin
            // Now and then the sender waits for the block to run dry.
            if ($urandom_range(0, 199) == 0) wait_for_responses();
            send_tick(next_switch_word(), $urandom_range(0, 7) != 0,
                      $urandom_range(0, 24) == 0, 1'b0, '0);
         end
      end

      wait_for_responses();
      repeat (8) @(posedge clock);
      if (owed_responses.size() != 0)
         report_mismatch("responses never delivered", owed_responses.size(), 0);

      $display("Covered %0d tick requests and %0d register writes; %0d responses checked.",
               ticks_sent, csr_writes, responses_seen);
      $display("Settings ran from zero delay and interval up to both maxima; %0d mismatches.",
               error_count);
      if (error_count == 0) begin
         $display("PASS input_word_debounce_and_decode_core");
      end else begin
         $display("FAIL input_word_debounce_and_decode_core");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: input_word_debounce_and_decode_core.f
src/iwdd_pkg.sv
src/iwdd_lane.sv
src/iwdd_merge.sv
src/iwdd_out_buf.sv
src/input_word_debounce_and_decode_core.sv
verif/tb_input_word_debounce_and_decode_core.sv
